// ===== hw/rtl/lsac_pkg.sv =====
// lsac_pkg: shared types and constants of the led strip animation controller
// mode codes, register indexes and register reset values
// no dependencies
`timescale 1ns / 1ps

package lsac_pkg;

	// animation modes, same code as the request field
	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_IDLE    = 3'd1,
		MODE_FWD     = 3'd2,
		MODE_RWD     = 3'd3,
		MODE_ARRIVED = 3'd4,
		MODE_ALARM   = 3'd5,
		MODE_ERROR   = 3'd6
	} mode_t;

	// request code that names no mode
	localparam logic [2:0] REQ_UNUSED = 3'd7;

	// configuration register indexes
	localparam logic [2:0] CFG_ENABLE    = 3'd0;
	localparam logic [2:0] CFG_LED_COUNT = 3'd1;
	localparam logic [2:0] CFG_STEP      = 3'd2;
	localparam logic [2:0] CFG_BREATH    = 3'd3;
	localparam logic [2:0] CFG_BLINK     = 3'd4;
	localparam logic [2:0] CFG_HOLD      = 3'd5;

	// register reset values; a zero write to step, breath or blink selects its reset value
	localparam logic [6:0]  LED_COUNT_RST = 7'd8;
	localparam logic [15:0] STEP_RST      = 16'd100;
	localparam logic [15:0] BREATH_RST    = 16'd25;
	localparam logic [15:0] BLINK_RST     = 16'd180;
	localparam logic [15:0] HOLD_RST      = 16'd140;

	// strip size
	localparam int MAX_LEDS_DEF = 64;

	// animation constants
	localparam logic [7:0]  BREATH_STEP    = 8'd5;
	localparam logic [7:0]  BREATH_START   = 8'd40;
	localparam logic [7:0]  LEVEL_FULL     = 8'd255;
	localparam logic [7:0]  CHASE_HEAD     = 8'd255;
	localparam logic [7:0]  CHASE_MID      = 8'd80;
	localparam logic [7:0]  CHASE_TAIL     = 8'd20;
	localparam logic [7:0]  AMBER_GREEN    = 8'd180;
	localparam logic [15:0] ERROR_MIN_PER  = 16'd60;

endpackage

// ===== hw/rtl/led_strip_animation_controller.sv =====
// led_strip_animation_controller: mode sequencer and frame streamer for an led strip
// depends on lsac_pkg
//
// channel   dir   handshake               payload
// cmd       in    cmd_valid / cmd_stall   operation, requested_state
// pix       out   pix_valid / pix_stall   pixel_index, red, green, blue, last_pixel, mode_now
// cfg       in    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a request or a tick without a frame leaves the sequencer ready; a frame tick streams one
// pixel per led in use (led count, zero counts as one, up to MAX_LEDS, 64 by default).
// a chase frame first reduces the chase position modulo the led count in a single subtractor,
// one subtraction per cycle; subtractions are needed only after the count shrank.
// the pixel output register lets the next item be taken while the last pixel waits.
// reset is asynchronous and sets all state to its reset values; no clearing pass is needed.
`timescale 1ns / 1ps

module led_strip_animation_controller
	import lsac_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        operation,
	input  logic [2:0]  requested_state,
	// pixel output
	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [5:0]  pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_pixel,
	output logic [2:0]  mode_now,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [6:0] MaxLit = 7'(MAX_LEDS);

	typedef enum logic [1:0] {
		ST_READY,
		ST_REDUCE,
		ST_STREAM
	} seq_t;

	seq_t        state_q;

	// configuration registers
	logic        enable_q;
	logic [6:0]  led_count_q;
	logic [15:0] step_q;
	logic [15:0] breath_q;
	logic [15:0] blink_q;
	logic [15:0] hold_q;

	// animation state
	mode_t       mode_q;
	logic [15:0] elapsed_q;
	logic        repaint_q;
	logic [5:0]  chase_pos_q;
	logic [7:0]  level_q;
	logic        rising_q;
	logic        blink_lit_q;
	logic        red_phase_q;

	// frame in progress
	logic [6:0]  rem_q;
	logic [5:0]  px_q;
	logic        chase_q;
	logic [5:0]  p0_q;
	logic [5:0]  p1_q;
	logic [5:0]  p2_q;
	logic [7:0]  frm_r_q;
	logic [7:0]  frm_g_q;
	logic [7:0]  frm_b_q;

	// pixel output register
	logic        pix_valid_q;
	logic [5:0]  pixel_index_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic        last_q;
	logic [2:0]  mode_now_q;

	// step a position up or down on a ring of n leds
	function automatic logic [5:0] ring_up(input logic [5:0] x, input logic [6:0] n);
		logic [6:0] s;
		s = {1'b0, x} + 7'd1;
		return (s == n) ? 6'd0 : s[5:0];
	endfunction

	function automatic logic [5:0] ring_dn(input logic [5:0] x, input logic [6:0] n);
		logic [6:0] top;
		top = n - 7'd1;
		return (x == 6'd0) ? top[5:0] : x - 6'd1;
	endfunction

	// leds in use
	logic [6:0] lit_n;
	always_comb begin
		if (led_count_q == 7'd0) begin
			lit_n = 7'd1;
		end else if (led_count_q > MaxLit) begin
			lit_n = MaxLit;
		end else begin
			lit_n = led_count_q;
		end
	end

	// configuration write decode
	logic        cfg_wr;
	logic [15:0] cfg_v;
	logic        cfg_differs;
	logic        cfg_new_enable;
	logic        cfg_force_off;
	always_comb begin
		cfg_wr = cfg_valid && cfg_ready;
		cfg_v = cfg_data;
		cfg_differs = 1'b0;
		unique case (cfg_index)
			CFG_ENABLE: begin
				cfg_differs = cfg_data[0] != enable_q;
			end
			CFG_LED_COUNT: begin
				cfg_differs = cfg_data[6:0] != led_count_q;
			end
			CFG_STEP: begin
				cfg_v = (cfg_data == 16'd0) ? STEP_RST : cfg_data;
				cfg_differs = cfg_v != step_q;
			end
			CFG_BREATH: begin
				cfg_v = (cfg_data == 16'd0) ? BREATH_RST : cfg_data;
				cfg_differs = cfg_v != breath_q;
			end
			CFG_BLINK: begin
				cfg_v = (cfg_data == 16'd0) ? BLINK_RST : cfg_data;
				cfg_differs = cfg_v != blink_q;
			end
			default: begin
			end
		endcase
		cfg_new_enable = (cfg_index == CFG_ENABLE) ? cfg_data[0] : enable_q;
		cfg_force_off = (cfg_index <= CFG_BLINK) && !cfg_new_enable;
	end

	// request decode
	logic [2:0] req_raw;
	logic       req_take;
	mode_t      req_mode;
	always_comb begin
		req_raw = enable_q ? requested_state : MODE_OFF;
		req_take = (req_raw != REQ_UNUSED) && (req_raw != mode_q)
			&& !((mode_q == MODE_ARRIVED) && (req_raw == MODE_IDLE));
		if (((mode_q == MODE_FWD) || (mode_q == MODE_RWD)) && (req_raw == MODE_IDLE)) begin
			req_mode = MODE_ARRIVED;
		end else begin
			req_mode = mode_t'(req_raw);
		end
	end

	// timer and period compare
	logic [15:0] el_inc;
	logic [15:0] err_per;
	logic [15:0] period;
	logic        expired;
	logic        fire;
	always_comb begin
		el_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
		err_per = ((blink_q >> 1) < ERROR_MIN_PER) ? ERROR_MIN_PER : (blink_q >> 1);
		unique case (mode_q)
			MODE_IDLE:    period = breath_q;
			MODE_FWD,
			MODE_RWD:     period = step_q;
			MODE_ARRIVED: period = hold_q;
			MODE_ALARM:   period = blink_q;
			MODE_ERROR:   period = err_per;
			default:      period = 16'hFFFF;
		endcase
		expired = el_inc >= period;
		fire = repaint_q || expired;
	end

	// breathing ramp step
	logic [8:0] lvl_sum;
	logic [7:0] lvl_next;
	logic       rise_next;
	always_comb begin
		lvl_sum = {1'b0, level_q} + {1'b0, BREATH_STEP};
		if (rising_q) begin
			if (lvl_sum >= {1'b0, LEVEL_FULL}) begin
				lvl_next = LEVEL_FULL;
				rise_next = 1'b0;
			end else begin
				lvl_next = lvl_sum[7:0];
				rise_next = 1'b1;
			end
		end else begin
			if (level_q <= BREATH_STEP) begin
				lvl_next = 8'd0;
				rise_next = 1'b1;
			end else begin
				lvl_next = level_q - BREATH_STEP;
				rise_next = 1'b0;
			end
		end
	end

	// tick outcome: which frame starts and its color
	logic       solid_go;
	logic       chase_go;
	logic [7:0] col_r;
	logic [7:0] col_g;
	logic [7:0] col_b;
	always_comb begin
		solid_go = 1'b0;
		chase_go = 1'b0;
		col_r = 8'd0;
		col_g = 8'd0;
		col_b = 8'd0;
		if (!enable_q || (mode_q == MODE_OFF)) begin
			solid_go = repaint_q;
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					solid_go = fire;
					col_b = lvl_next;
				end
				MODE_FWD,
				MODE_RWD: begin
					chase_go = fire;
				end
				MODE_ALARM: begin
					solid_go = fire;
					col_r = blink_lit_q ? 8'd0 : LEVEL_FULL;
				end
				MODE_ERROR: begin
					solid_go = fire;
					col_r = LEVEL_FULL;
					col_g = red_phase_q ? AMBER_GREEN : 8'd0;
				end
				default: begin
				end
			endcase
		end
	end

	// subtractor for the modulo reduction, and chase positions
	logic       rem_ge;
	logic [6:0] rem_sub;
	logic [5:0] c_pos;
	logic [5:0] p1_pos;
	logic [5:0] p2_pos;
	logic [5:0] cp_next;
	always_comb begin
		rem_ge = rem_q >= lit_n;
		rem_sub = rem_q - lit_n;
		c_pos = rem_q[5:0];
		if (mode_q == MODE_FWD) begin
			p1_pos = ring_dn(c_pos, lit_n);
			p2_pos = ring_dn(p1_pos, lit_n);
			cp_next = ring_up(c_pos, lit_n);
		end else begin
			p1_pos = ring_up(c_pos, lit_n);
			p2_pos = ring_up(p1_pos, lit_n);
			cp_next = ring_dn(chase_pos_q, lit_n);
		end
	end

	// color of the pixel being loaded
	logic [7:0] px_g;
	logic       px_last;
	logic       load;
	always_comb begin
		if (!chase_q) begin
			px_g = frm_g_q;
		end else if (px_q == p0_q) begin
			px_g = CHASE_HEAD;
		end else if ((lit_n >= 7'd2) && (px_q == p1_q)) begin
			px_g = CHASE_MID;
		end else if ((lit_n >= 7'd3) && (px_q == p2_q)) begin
			px_g = CHASE_TAIL;
		end else begin
			px_g = 8'd0;
		end
		px_last = ({1'b0, px_q} + 7'd1) == lit_n;
		load = !pix_valid_q || !pix_stall;
	end

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			enable_q <= 1'b0;
			led_count_q <= LED_COUNT_RST;
			step_q <= STEP_RST;
			breath_q <= BREATH_RST;
			blink_q <= BLINK_RST;
			hold_q <= HOLD_RST;
			mode_q <= MODE_OFF;
			elapsed_q <= 16'd0;
			repaint_q <= 1'b1;
			chase_pos_q <= 6'd0;
			level_q <= 8'd0;
			rising_q <= 1'b1;
			blink_lit_q <= 1'b0;
			red_phase_q <= 1'b0;
			rem_q <= 7'd0;
			px_q <= 6'd0;
			chase_q <= 1'b0;
			p0_q <= 6'd0;
			p1_q <= 6'd0;
			p2_q <= 6'd0;
			frm_r_q <= 8'd0;
			frm_g_q <= 8'd0;
			frm_b_q <= 8'd0;
			pix_valid_q <= 1'b0;
			pixel_index_q <= 6'd0;
			red_q <= 8'd0;
			green_q <= 8'd0;
			blue_q <= 8'd0;
			last_q <= 1'b0;
			mode_now_q <= 3'd0;
		end else begin
			// configuration write
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_ENABLE:    enable_q <= cfg_data[0];
					CFG_LED_COUNT: led_count_q <= cfg_data[6:0];
					CFG_STEP:      step_q <= cfg_v;
					CFG_BREATH:    breath_q <= cfg_v;
					CFG_BLINK:     blink_q <= cfg_v;
					CFG_HOLD:      hold_q <= cfg_data;
					default: begin
					end
				endcase
				if (cfg_differs) begin
					repaint_q <= 1'b1;
				end
				if (cfg_force_off) begin
					mode_q <= MODE_OFF;
				end
			end

			unique case (state_q)
				ST_READY: begin
					if (cmd_valid) begin
						if (operation) begin
							// state request
							if (req_take) begin
								mode_q <= req_mode;
								elapsed_q <= 16'd0;
								repaint_q <= 1'b1;
								unique case (req_mode)
									MODE_IDLE: begin
										level_q <= BREATH_START;
										rising_q <= 1'b1;
									end
									MODE_FWD,
									MODE_RWD:   chase_pos_q <= 6'd0;
									MODE_ALARM: blink_lit_q <= 1'b0;
									MODE_ERROR: red_phase_q <= 1'b0;
									default: begin
									end
								endcase
							end
						end else begin
							// millisecond tick
							elapsed_q <= el_inc;
							if (solid_go || chase_go) begin
								repaint_q <= 1'b0;
								if (enable_q && (mode_q != MODE_OFF)) begin
									elapsed_q <= 16'd0;
								end
								frm_r_q <= col_r;
								frm_g_q <= col_g;
								frm_b_q <= col_b;
								chase_q <= chase_go;
								px_q <= 6'd0;
								rem_q <= {1'b0, chase_pos_q};
								state_q <= chase_go ? ST_REDUCE : ST_STREAM;
							end
							if (enable_q && (mode_q == MODE_IDLE) && fire) begin
								level_q <= lvl_next;
								rising_q <= rise_next;
							end
							if (enable_q && (mode_q == MODE_ALARM) && fire) begin
								blink_lit_q <= !blink_lit_q;
							end
							if (enable_q && (mode_q == MODE_ERROR) && fire) begin
								red_phase_q <= !red_phase_q;
							end
							// arrived hold runs out into idle without a frame
							if (enable_q && (mode_q == MODE_ARRIVED)) begin
								repaint_q <= 1'b0;
								if (expired) begin
									mode_q <= MODE_IDLE;
									elapsed_q <= 16'd0;
									level_q <= BREATH_START;
									rising_q <= 1'b1;
									repaint_q <= 1'b1;
								end
							end
						end
					end
				end
				ST_REDUCE: begin
					// one subtraction per cycle until the position is below the count
					if (rem_ge) begin
						rem_q <= rem_sub;
					end else begin
						p0_q <= c_pos;
						p1_q <= p1_pos;
						p2_q <= p2_pos;
						chase_pos_q <= cp_next;
						state_q <= ST_STREAM;
					end
				end
				ST_STREAM: begin
					if (load) begin
						px_q <= px_q + 6'd1;
						if (px_last) begin
							state_q <= ST_READY;
						end
					end
				end
				default: begin
					state_q <= ST_READY;
				end
			endcase

			// pixel output register
			if ((state_q == ST_STREAM) && load) begin
				pix_valid_q <= 1'b1;
				pixel_index_q <= px_q;
				red_q <= frm_r_q;
				green_q <= px_g;
				blue_q <= frm_b_q;
				last_q <= px_last;
				mode_now_q <= mode_q;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_stall = state_q != ST_READY;
	assign cfg_ready = 1'b1;
	assign pix_valid = pix_valid_q;
	assign pixel_index = pixel_index_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
	assign last_pixel = last_q;
	assign mode_now = mode_now_q;

endmodule

// ===== hw/rtl/lsac_checker.sv =====
// lsac_checker: port-level checks of the led strip animation controller
// bound to led_strip_animation_controller; no package needed
`timescale 1ns / 1ps

module lsac_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic       operation,
	input logic       pix_valid,
	input logic       pix_stall,
	input logic [5:0] pixel_index,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       last_pixel,
	input logic [2:0] mode_now
);

	// pixels of a frame follow without a gap, in order, under one mode
	a_frame_order: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && !last_pixel |=>
			pix_valid && (pixel_index == $past(pixel_index) + 6'd1) && $stable(mode_now))
		else $error("frame pixels out of order");

	// a frame starts at pixel zero
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid) |-> pixel_index == 6'd0)
		else $error("frame does not start at pixel zero");

	// no item is taken while a frame is still streaming
	a_busy_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !last_pixel |-> cmd_stall)
		else $error("item taken during a frame");

	// a state request taken while no pixel is valid causes no pixel
	a_request_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && operation && !pix_valid |=> !pix_valid)
		else $error("pixel after a state request");

	// a stalled pixel holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=>
			pix_valid && $stable(pixel_index) && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(last_pixel))
		else $error("stalled pixel changed");

endmodule

bind led_strip_animation_controller lsac_checker u_lsac_checker (.*);
